// ----- src/tfc_pkg.sv -----
package tfc_pkg;

   // Source format codes
   localparam logic [3:0] FMT_A8       = 4'd0;
   localparam logic [3:0] FMT_I8       = 4'd1;
   localparam logic [3:0] FMT_AI44     = 4'd2;
   localparam logic [3:0] FMT_RGB565   = 4'd3;
   localparam logic [3:0] FMT_ARGB1555 = 4'd4;
   localparam logic [3:0] FMT_ARGB4444 = 4'd5;
   localparam logic [3:0] FMT_AI88     = 4'd6;
   localparam logic [3:0] FMT_ARGB8888 = 4'd7;

   // Register indexes on the configuration port
   localparam logic REG_SRC_FORMAT  = 1'b0;
   localparam logic REG_PACKED_MODE = 1'b1;

   localparam int  CSR_ADDR_W = 3;
   localparam int  CSR_DATA_W = 32;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [31:0] texel_in;
      logic        last_in;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] texel_out;
      logic [2:0]  out_bytes;
      logic [2:0]  src_bytes;
      logic        format_error;
      logic        last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0] src_format;
      logic       packed_mode;
   } cfg_type;

endpackage

// ----- src/tfc_convert.sv -----
module tfc_convert
   import tfc_pkg::*;
(
   input  cfg_type         cfg,
   input  req_payload_type src,
   output rsp_payload_type dst
);

   logic [31:0] t;
   logic [2:0]  sb;

   // Source width per format
   always_comb begin
      case (cfg.src_format)
         FMT_A8, FMT_I8, FMT_AI44: begin
            sb = 3'd1;
         end
         FMT_RGB565, FMT_ARGB1555, FMT_ARGB4444, FMT_AI88: begin
            sb = 3'd2;
         end
         FMT_ARGB8888: begin
            sb = 3'd4;
         end
         default: begin
            sb = 3'd0;
         end
      endcase
   end

   // Drop source bits above the format width
   always_comb begin
      case (sb)
         3'd1:    t = {24'd0, src.texel_in[7:0]};
         3'd2:    t = {16'd0, src.texel_in[15:0]};
         3'd4:    t = src.texel_in;
         default: t = 32'd0;
      endcase
   end

   // Rearrange the texel bits
   always_comb begin
      dst.src_bytes    = sb;
      dst.last_out     = src.last_in;
      dst.format_error = 1'b0;
      dst.texel_out    = 32'd0;
      dst.out_bytes    = 3'd0;
      if (sb == 3'd0) begin
         dst.format_error = 1'b1;
      end else if (cfg.src_format == FMT_AI44) begin
         // AI44 always expands to nibble-doubled luminance-alpha
         dst.texel_out = {16'd0, t[7:4], t[7:4], t[3:0], t[3:0]};
         dst.out_bytes = 3'd2;
      end else if (cfg.packed_mode) begin
         dst.texel_out = t;
         dst.out_bytes = sb;
      end else begin
         case (cfg.src_format)
            FMT_A8: begin
               dst.texel_out = {16'd0, t[7:0], t[7:0]};
               dst.out_bytes = 3'd2;
            end
            FMT_I8: begin
               dst.texel_out = {ALPHA_OPAQUE, t[7:0], t[7:0], t[7:0]};
               dst.out_bytes = 3'd4;
            end
            FMT_RGB565: begin
               dst.texel_out = {ALPHA_OPAQUE, t[4:0], 3'd0, t[10:5], 2'd0,
                                t[15:11], 3'd0};
               dst.out_bytes = 3'd4;
            end
            FMT_ARGB1555: begin
               // rotate left by one within 16 bits
               dst.texel_out = {16'd0, t[14:0], t[15]};
               dst.out_bytes = 3'd2;
            end
            FMT_AI88: begin
               dst.texel_out = {t[15:8], t[7:0], t[7:0], t[7:0]};
               dst.out_bytes = 3'd4;
            end
            FMT_ARGB4444: begin
               dst.texel_out = {t[15:12], 4'd0, t[3:0], 4'd0,
                                t[7:4], 4'd0, t[11:8], 4'd0};
               dst.out_bytes = 3'd4;
            end
            default: begin
               // ARGB8888: swap red and blue bytes
               dst.texel_out = {t[31:24], t[7:0], t[15:8], t[23:16]};
               dst.out_bytes = 3'd4;
            end
         endcase
      end
   end

endmodule

// ----- src/texel_format_converter_top.sv -----
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_data (req_payload_type)
// rsp       out        rsp_valid / rsp_stall   rsp_data (rsp_payload_type)
// csr       in         psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// A texel that transfers on req passes through an input register, the format
// shuffle, then the result register before it is offered on rsp.
// One texel per cycle is sustained while rsp is not stalled.
// Synchronous active-high reset clears both valid flags and the configuration.
// A stall on rsp holds the result; the input register keeps accepting until
// it is full, then req_stall rises.
module texel_format_converter_top
   import tfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg_ff, cfg_in;
   logic            csr_write;
   logic            csr_index;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type conv_data;
   logic            out_take;
   logic            in_take;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SRC_FORMAT:  cfg_in.src_format  = pwdata[3:0];
            REG_PACKED_MODE: cfg_in.packed_mode = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SRC_FORMAT:  prdata = {{(CSR_DATA_W-4){1'b0}}, cfg_ff.src_format};
         REG_PACKED_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.packed_mode};
         default:         prdata = '0;
      endcase
   end

   // Pipeline advance: result register frees when empty or taken
   assign out_take  = !out_valid_ff || !rsp_stall;
   assign in_take   = !in_valid_ff || out_take;
   assign req_stall = !in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (in_take) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   tfc_convert u_convert (
      .cfg (cfg_ff),
      .src (in_data_ff),
      .dst (conv_data)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_take) begin
         out_valid_in = in_valid_ff;
         out_data_in  = conv_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
